### rtl/ipv4_dotted_decimal_parser_defines.svh
// assertion macros used by the checker file
`ifndef IPV4_DOTTED_DECIMAL_PARSER_DEFINES_SVH
`define IPV4_DOTTED_DECIMAL_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define IPV4DD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define IPV4DD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ipv4dd_pkg.sv
package ipv4dd_pkg;

  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [8:0] OCTET_MAX = 9'd255;
  localparam logic [8:0] VALUE_SAT = 9'd256;
  localparam logic [1:0] LAST_OCTET = 2'd3;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] address;
    logic        ok;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  octet_index;
    phase_t      phase;
    logic        minus_seen;
    logic [8:0]  octet_value;
    logic [23:0] upper_octets;
    logic        failed;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    octet_index:  2'd0,
    phase:        PH_SPACE,
    minus_seen:   1'b0,
    octet_value:  9'd0,
    upper_octets: 24'd0,
    failed:       1'b0
  };

endpackage

### rtl/ipv4dd_step.sv
module ipv4dd_step (
  input  ipv4dd_pkg::parse_state_t state_i,
  input  ipv4dd_pkg::in_beat_t     beat_i,
  output ipv4dd_pkg::parse_state_t state_o,
  output ipv4dd_pkg::out_beat_t    result_o
);

  // close the current octet; dot_i says the terminator is a dot
  function automatic ipv4dd_pkg::parse_state_t finish_octet(
    ipv4dd_pkg::parse_state_t s,
    logic                     dot_i
  );
    ipv4dd_pkg::parse_state_t r;
    logic                     bad;
    r   = s;
    bad = (s.octet_value > ipv4dd_pkg::OCTET_MAX) ||
          (s.minus_seen && (s.octet_value != 9'd0));
    if (bad) begin
      r.failed = 1'b1;
    end else if (s.octet_index == ipv4dd_pkg::LAST_OCTET) begin
      r.phase = ipv4dd_pkg::PH_DONE;
    end else if (!dot_i) begin
      r.failed = 1'b1;
    end else begin
      r.upper_octets = {s.upper_octets[15:0], s.octet_value[7:0]};
      r.octet_index  = s.octet_index + 2'd1;
      r.phase        = ipv4dd_pkg::PH_SPACE;
      r.minus_seen   = 1'b0;
      r.octet_value  = 9'd0;
    end
    return r;
  endfunction

  logic                     is_digit;
  logic                     is_blank;
  logic                     is_sign;
  logic [3:0]               digit;
  logic [11:0]              acc;
  ipv4dd_pkg::parse_state_t taken;
  ipv4dd_pkg::parse_state_t closed;
  logic                     good;

  assign is_digit = (beat_i.ch >= ipv4dd_pkg::CH_ZERO) && (beat_i.ch <= ipv4dd_pkg::CH_NINE);
  assign is_blank = (beat_i.ch == ipv4dd_pkg::CH_SPACE) ||
                    ((beat_i.ch >= ipv4dd_pkg::CH_TAB) && (beat_i.ch <= ipv4dd_pkg::CH_CR));
  assign is_sign  = (beat_i.ch == ipv4dd_pkg::CH_PLUS) || (beat_i.ch == ipv4dd_pkg::CH_MINUS);
  assign digit    = beat_i.ch[3:0];
  // value * 10 + digit as two shifts and adds
  assign acc      = {state_i.octet_value, 3'b000} + {2'b00, state_i.octet_value, 1'b0}
                    + {8'd0, digit};

  always_comb begin
    taken = state_i;
    if (!state_i.failed) begin
      unique case (state_i.phase)
        ipv4dd_pkg::PH_SPACE: begin
          if (is_blank) begin
            taken = state_i;
          end else if (is_sign) begin
            taken.minus_seen = (beat_i.ch == ipv4dd_pkg::CH_MINUS);
            taken.phase      = ipv4dd_pkg::PH_SIGN;
          end else if (is_digit) begin
            taken.octet_value = {5'd0, digit};
            taken.phase       = ipv4dd_pkg::PH_DIGITS;
          end else begin
            taken.failed = 1'b1;
          end
        end
        ipv4dd_pkg::PH_SIGN: begin
          if (is_digit) begin
            taken.octet_value = {5'd0, digit};
            taken.phase       = ipv4dd_pkg::PH_DIGITS;
          end else begin
            taken.failed = 1'b1;
          end
        end
        ipv4dd_pkg::PH_DIGITS: begin
          if (is_digit) begin
            taken.octet_value = (acc > {3'd0, ipv4dd_pkg::VALUE_SAT}) ?
                                ipv4dd_pkg::VALUE_SAT : acc[8:0];
          end else begin
            taken = finish_octet(state_i, beat_i.ch == ipv4dd_pkg::CH_DOT);
          end
        end
        ipv4dd_pkg::PH_DONE: begin
          taken = state_i;
        end
        default: begin
          taken = state_i;
        end
      endcase
    end
  end

  always_comb begin
    closed = taken;
    // end of string ends an octet in progress, never as a dot
    if (!taken.failed && (taken.phase == ipv4dd_pkg::PH_DIGITS)) begin
      closed = finish_octet(taken, 1'b0);
    end
    good = !closed.failed && (closed.phase == ipv4dd_pkg::PH_DONE);
    result_o.ok      = good;
    result_o.address = good ? {closed.upper_octets, closed.octet_value[7:0]} : 32'd0;
    state_o = beat_i.last ? ipv4dd_pkg::STATE_RESET : taken;
  end

endmodule

### rtl/ipv4_dotted_decimal_parser.sv
// channel | ports                          | beat
// --------+--------------------------------+----------------------------------
// input   | in_valid, in_stall, in_beat    | one text character, last flag
// result  | out_valid, out_stall, out_beat | 32-bit address, ok flag
//
// one character per cycle, sustained while no last character waits on a stalled
// result; a result leaves through the input register and the result register
// around the combinational parse step
// rst_n is synchronous, active low, and returns the parser to its empty state
// out_stall only holds back a last character while a result still waits;
// other characters keep flowing into the parser under a stalled result
module ipv4_dotted_decimal_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ipv4dd_pkg::in_beat_t  in_beat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ipv4dd_pkg::out_beat_t out_beat
);

  // input register
  logic                     in_valid_r;
  logic                     in_valid_nxt;
  ipv4dd_pkg::in_beat_t     in_beat_r;

  // parser state
  ipv4dd_pkg::parse_state_t state_r;
  ipv4dd_pkg::parse_state_t state_nxt;

  // result register
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  ipv4dd_pkg::out_beat_t    out_beat_r;
  ipv4dd_pkg::out_beat_t    step_result;

  logic                     out_busy;
  logic                     advance;

  // result register cannot take a new beat this cycle
  assign out_busy = out_valid_r && out_stall;
  // a held character moves into the parser unless it needs a busy result slot
  assign advance  = in_valid_r && !(in_beat_r.last && out_busy);
  // the input register frees up whenever its beat advances
  assign in_stall = in_valid_r && !advance;

  ipv4dd_step u_step (
    .state_i  (state_r),
    .beat_i   (in_beat_r),
    .state_o  (state_nxt),
    .result_o (step_result)
  );

  always_comb begin
    in_valid_nxt = in_stall ? in_valid_r : in_valid;
    if (out_busy) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = advance && in_beat_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ipv4dd_pkg::STATE_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_beat_r <= in_beat;
    end
    if (advance && in_beat_r.last && !out_busy) begin
      out_beat_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

### rtl/ipv4dd_checker.sv
`include "ipv4_dotted_decimal_parser_defines.svh"

module ipv4dd_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input ipv4dd_pkg::in_beat_t  in_beat,
  input logic                  out_valid,
  input logic                  out_stall,
  input ipv4dd_pkg::out_beat_t out_beat
);

  `IPV4DD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat), "held result changed")

  `IPV4DD_ASSERT_NOW(a_fail_zero, out_valid, out_beat.ok || (out_beat.address == 32'd0), "failed parse with nonzero address")

  `IPV4DD_ASSERT_NOW(a_no_stall_free, !(out_valid && out_stall), !in_stall, "input stalled while result side is free")

  `IPV4DD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_beat), "stalled input beat changed")

endmodule

bind ipv4_dotted_decimal_parser ipv4dd_checker u_ipv4dd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // result-side stall patterns
  typedef enum int {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_TOGGLE
  } sink_mode_t;

  // one directed address string; want is used only where typed is set
  typedef struct {
    string                 text;
    int                    nul_pos;
    bit                    typed;
    ipv4dd_pkg::out_beat_t want;
  } text_row_t;

  localparam int RANDOM_CHARS    = 1900;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 10;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  ipv4dd_pkg::in_beat_t  in_beat   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ipv4dd_pkg::out_beat_t out_beat;

  // shadow copy of the parser state and the addresses it predicts
  ipv4dd_pkg::parse_state_t shadow = ipv4dd_pkg::STATE_RESET;
  ipv4dd_pkg::out_beat_t    pending_parses[$];

  text_row_t rows[7];

  int  burst_left    = 0;
  int  char_count    = 0;
  int  random_chars  = 0;
  int  text_count    = 0;
  int  ok_count      = 0;
  int  checked_count = 0;
  int  error_count   = 0;
  bit  hold_req      = 1'b0;

  ipv4_dotted_decimal_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always #2 clk = ~clk;

  // append one character to a text queue
  function automatic void add_char(ref logic [7:0] q[$], input logic [7:0] c);
    q.insert(q.size(), c);
  endfunction

  // the digits of the current octet are over; at_dot says a dot ended them
  function automatic void close_octet(input bit at_dot);
    if (shadow.octet_value > ipv4dd_pkg::OCTET_MAX ||
        (shadow.minus_seen && shadow.octet_value != 9'd0)) begin
      shadow.failed = 1'b1;
    end else if (shadow.octet_index == ipv4dd_pkg::LAST_OCTET) begin
      shadow.phase = ipv4dd_pkg::PH_DONE;
    end else if (!at_dot) begin
      shadow.failed = 1'b1;
    end else begin
      shadow.upper_octets = {shadow.upper_octets[15:0], shadow.octet_value[7:0]};
      shadow.octet_index  = shadow.octet_index + 2'd1;
      shadow.phase        = ipv4dd_pkg::PH_SPACE;
      shadow.minus_seen   = 1'b0;
      shadow.octet_value  = 9'd0;
    end
  endfunction

  // advance the shadow parser by one character; returns 1 when a result is due
  function automatic bit parse_char(input logic [7:0] c, input logic lst,
                                    output ipv4dd_pkg::out_beat_t res);
    int unsigned acc;
    bit          blank;
    bit          digit;
    blank = (c == ipv4dd_pkg::CH_SPACE) ||
            (c >= ipv4dd_pkg::CH_TAB && c <= ipv4dd_pkg::CH_CR);
    digit = (c >= ipv4dd_pkg::CH_ZERO) && (c <= ipv4dd_pkg::CH_NINE);
    res   = '0;
    // after an error or a finished fourth octet, characters fall through
    if (!shadow.failed && shadow.phase != ipv4dd_pkg::PH_DONE) begin
      case (shadow.phase)
        ipv4dd_pkg::PH_SPACE: begin
          if (c == ipv4dd_pkg::CH_PLUS || c == ipv4dd_pkg::CH_MINUS) begin
            shadow.minus_seen = (c == ipv4dd_pkg::CH_MINUS);
            shadow.phase      = ipv4dd_pkg::PH_SIGN;
          end else if (digit) begin
            shadow.octet_value = 9'(c - ipv4dd_pkg::CH_ZERO);
            shadow.phase       = ipv4dd_pkg::PH_DIGITS;
          end else if (!blank) begin
            shadow.failed = 1'b1;
          end
        end
        ipv4dd_pkg::PH_SIGN: begin
          if (digit) begin
            shadow.octet_value = 9'(c - ipv4dd_pkg::CH_ZERO);
            shadow.phase       = ipv4dd_pkg::PH_DIGITS;
          end else begin
            shadow.failed = 1'b1;
          end
        end
        default: begin
          if (digit) begin
            // accumulator saturates one above the largest octet
            acc = shadow.octet_value * 10 + (c - ipv4dd_pkg::CH_ZERO);
            shadow.octet_value = (acc > ipv4dd_pkg::VALUE_SAT) ?
                                 ipv4dd_pkg::VALUE_SAT : acc[8:0];
          end else begin
            close_octet(c == ipv4dd_pkg::CH_DOT);
          end
        end
      endcase
    end
    if (!lst)
      return 1'b0;
    // end of string acts as a terminating non-digit
    if (!shadow.failed && shadow.phase == ipv4dd_pkg::PH_DIGITS)
      close_octet(1'b0);
    if (!shadow.failed && shadow.phase == ipv4dd_pkg::PH_DONE)
      res = '{address: {shadow.upper_octets, shadow.octet_value[7:0]}, ok: 1'b1};
    shadow = ipv4dd_pkg::STATE_RESET;
    return 1'b1;
  endfunction

  // mostly well-formed address text with random content, sometimes damaged
  function automatic void make_address(ref logic [7:0] txt[$]);
    int    val;
    int    pick;
    string digits;
    txt.delete();
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2))
          add_char(txt, ($urandom_range(0, 2) == 0) ? ipv4dd_pkg::CH_SPACE :
                        8'(ipv4dd_pkg::CH_TAB + $urandom_range(0, 4)));
      pick = $urandom_range(0, 11);
      if (pick == 0)
        add_char(txt, ipv4dd_pkg::CH_PLUS);
      else if (pick == 1)
        add_char(txt, ipv4dd_pkg::CH_MINUS);
      val = $urandom_range(0, 255);
      // minus zero is legal, so most minus-signed octets are zero
      if (pick == 1 && $urandom_range(0, 3) != 0)
        val = 0;
      case ($urandom_range(0, 23))
        0:       val = $urandom_range(256, 999);
        1:       val = -1;
        2:       val = 255;
        3:       val = 0;
        4:       val = $urandom_range(1000, 999999);
        default: ;
      endcase
      // a negative val leaves the octet without digits
      if (val >= 0) begin
        if ($urandom_range(0, 7) == 0)
          add_char(txt, ipv4dd_pkg::CH_ZERO);
        digits = $sformatf("%0d", val);
        for (int i = 0; i < digits.len(); i++)
          add_char(txt, 8'(digits[i]));
      end
      if (k < 3)
        add_char(txt, ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255)) :
                      ipv4dd_pkg::CH_DOT);
      else if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3))
          add_char(txt, 8'($urandom_range(0, 255)));
    end
    case ($urandom_range(0, 15))
      0:       txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      1:       txt.delete($urandom_range(0, txt.size() - 1));
      2:       txt = txt[0:$urandom_range(0, txt.size() - 1)];
      default: ;
    endcase
  endfunction

  // offer one character, wait for its handshake, predict what it causes
  task automatic send_char(input logic [7:0] c, input logic lst,
                           input bit typed, input ipv4dd_pkg::out_beat_t want);
    int                    gap;
    ipv4dd_pkg::out_beat_t res;
    // bursts of beats with random gaps between them
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_beat  <= '{ch: c, last: lst};
    do
      @(posedge clk);
    while (in_stall);
    char_count++;
    random_chars++;
    if (parse_char(c, lst, res)) begin
      pending_parses.insert(pending_parses.size(), typed ? want : res);
      if (pending_parses[$].ok)
        ok_count++;
    end
    @(negedge clk);
  endtask

  task automatic send_text(ref logic [7:0] txt[$], input bit typed,
                           input ipv4dd_pkg::out_beat_t want);
    foreach (txt[i])
      send_char(txt[i], i == txt.size() - 1, typed, want);
    text_count++;
  endtask

  initial begin : stimulus
    logic [7:0] txt[$];
    // directed strings: extreme characters, extreme addresses, error paths
    rows[0] = '{"@", 0, 1'b1, {32'h0000_0000, 1'b0}};   // nul character
    rows[1] = '{"\377", -1, 1'b1, {32'h0000_0000, 1'b0}};
    rows[2] = '{"9.", -1, 1'b1, {32'h0000_0000, 1'b0}}; // empty octet at the end
    rows[3] = '{"0.0.0.0", -1, 1'b1, {32'h0000_0000, 1'b1}};
    rows[4] = '{"255.255.255.255", -1, 1'b1, {32'hffff_ffff, 1'b1}};
    rows[5] = '{"-0.+1. 2.\t3z", -1, 1'b0, '0}; // signs, blanks, trailing junk
    rows[6] = '{"1x.2", -1, 1'b0, '0};          // error then ignored tail

    // synchronous reset, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[r]) begin
      txt.delete();
      // a string cannot carry a nul, so it is patched in by position
      for (int j = 0; j < rows[r].text.len(); j++)
        add_char(txt, (j == rows[r].nul_pos) ? 8'h00 : 8'(rows[r].text[j]));
      send_text(txt, rows[r].typed, rows[r].want);
    end

    // random part; the sink takes its long hold-off right away
    hold_req     = 1'b1;
    random_chars = 0;
    while (random_chars < RANDOM_CHARS) begin
      if ($urandom_range(0, 6) == 0) begin
        txt.delete();
        repeat ($urandom_range(1, 6))
          add_char(txt, 8'($urandom_range(0, 255)));
      end else begin
        make_address(txt);
      end
      send_text(txt, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain outstanding addresses, then watch a little longer for strays
    while (pending_parses.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d characters in %0d strings, %0d addresses checked, %0d parsed ok",
             char_count, text_count, checked_count, ok_count);
    if (error_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // result side: random stall patterns plus one long hold-off so the parser backs up
  initial begin : result_sink
    sink_mode_t mode;
    int         seg_left;
    int         hold_left;
    bit         hold_done;
    mode      = SINK_OPEN;
    seg_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = sink_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        case (mode)
          SINK_OPEN:  out_stall <= 1'b0;
          SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          SINK_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:    out_stall <= !out_stall;
        endcase
      end
    end
  end

  // compare each accepted result beat with the oldest predicted address
  always @(posedge clk) begin : result_check
    ipv4dd_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_count++;
      if (pending_parses.size() == 0) begin
        $display("%0t: unexpected result, address %h ok %b",
                 $time, out_beat.address, out_beat.ok);
        error_count++;
      end else begin
        want = pending_parses.pop_front();
        if (out_beat.address !== want.address) begin
          $display("%0t: address mismatch, expected %h actual %h",
                   $time, want.address, out_beat.address);
          error_count++;
        end
        if (out_beat.ok !== want.ok) begin
          $display("%0t: ok mismatch, expected %b actual %b", $time, want.ok, out_beat.ok);
          error_count++;
        end
      end
    end
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2ms;
    $display("tb_top: timeout with %0d addresses outstanding", pending_parses.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/ipv4dd_pkg.sv
rtl/ipv4dd_step.sv
rtl/ipv4_dotted_decimal_parser.sv
rtl/ipv4dd_checker.sv
verif/tb_top.sv
